### hw/rtl/spindle_encoder_position_rpm_tracker_core_defines.svh
// assertion macros shared by the spindle tracker rtl
`ifndef SPINDLE_ENCODER_POSITION_RPM_TRACKER_CORE_DEFINES_SVH
`define SPINDLE_ENCODER_POSITION_RPM_TRACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPDL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define SPDL_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define SPDL_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPDL_ASSERT_NEXT(lbl, ante, cons, msg)
`define SPDL_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hw/rtl/spdl_pkg.sv
// types and constants of the spindle position and rpm tracker
`default_nettype none

package spdl_pkg;

    localparam int PPR_W     = 16;
    localparam int DELTA_W   = 16;
    localparam int ANGLE_W   = 17;
    localparam int POS_W     = ANGLE_W + 1;
    localparam int ACC_W     = 32;
    localparam int STAMP_W   = 48;
    localparam int RPM_W     = 16;
    localparam int QUOT_W    = RPM_W + 1;
    localparam int MUL_K_W   = 26;
    localparam int NUM_W     = ACC_W + MUL_K_W;
    localparam int STALE_W   = 20;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [MUL_K_W-1:0] US_PER_MINUTE = MUL_K_W'(60000000);
    localparam logic [STALE_W-1:0] STALE_US      = STALE_W'(1000000);
    localparam logic [RPM_W-1:0]   RPM_MAX       = '1;
    localparam logic [PPR_W-1:0]   PPR_RESET     = PPR_W'(2048);

    typedef enum logic [ADDR_W-3:0] {
        REG_PULSES_PER_REV = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] count_delta;
        logic [STAMP_W-1:0]        time_us;
        logic                      consume;
    } item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [ACC_W-1:0]   taken_delta;
        logic [RPM_W-1:0]          rpm;
    } result_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_rpm;
        logic apply;
        logic latch;
        logic prep;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/spindle_encoder_position_rpm_tracker_core.sv
// top level of the spindle encoder position and rpm tracker
//
//   port group   direction   handshake               payload
//   item         in          item_valid/item_ready   spdl_pkg::item_t
//   result       out         result_valid/result_ready spdl_pkg::result_t
//   apb          in/out      psel/penable/pready     pulses_per_rev at 0x0
//
// a request runs through two 17-step passes of the shared serial divider
// (angle remainder, then rpm quotient) plus the sequencer steps around them,
// and the next request is accepted only once the sequencer is back in idle.
// the finished result sits in an output register; a new request is taken
// while it waits, and the block stalls only if the following result is ready
// before the previous one has gone. reset clears all tracking state at once.
`default_nettype none

module spindle_encoder_position_rpm_tracker_core #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire spdl_pkg::item_t                 item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output spdl_pkg::result_t                    result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spdl_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [spdl_pkg::DATA_W-1:0]     pwdata,
    output logic [spdl_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic [spdl_pkg::PPR_W-1:0] ppr_reg, ppr_next;
    logic                       hit_ppr;
    spdl_pkg::cmd_t             cmd;
    spdl_pkg::stat_t            stat;

    assign pready  = 1'b1;
    assign hit_ppr = paddr[spdl_pkg::ADDR_W-1:2] == spdl_pkg::REG_PULSES_PER_REV;

    always_comb
    begin
        ppr_next = ppr_reg;
        if (psel && penable && pwrite && pready && hit_ppr)
        begin
            ppr_next = pwdata[spdl_pkg::PPR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg <= spdl_pkg::PPR_RESET;
        end
        else
        begin
            ppr_reg <= ppr_next;
        end
    end

    assign prdata = hit_ppr ? spdl_pkg::DATA_W'(ppr_reg) : '0;

    spdl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    spdl_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .ppr    (ppr_reg),
        .result (result)
    );

endmodule

`default_nettype wire

### hw/rtl/spdl_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
`include "spindle_encoder_position_rpm_tracker_core_defines.svh"

module spdl_div #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [NUM_W-1:0]            num,
    input  wire logic [DEN_W-1:0]            den,
    output logic                             done,
    output logic [spdl_pkg::QUOT_W-1:0]      quot,
    output logic [DEN_W-1:0]                 rem,
    output logic                             ovf
);

    localparam int QW = spdl_pkg::QUOT_W;
    localparam int W  = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
    localparam int CW = $clog2(QW + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsh_reg, dsh_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          ovf_reg, ovf_next;
    logic [W-1:0]  den_ext;
    logic          ge;

    assign den_ext = W'(den);
    assign ge      = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (start)
        begin
            rem_next  = W'(num);
            dsh_next  = den_ext << (QW - 1);
            quot_next = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
            ovf_next  = W'(num) >= (den_ext << QW);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[QW-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[DEN_W-1:0];
    assign ovf  = ovf_reg;

    `SPDL_ASSERT_NEVER(a_start_while_busy, start && busy_reg, "divider started while busy")

endmodule

`default_nettype wire

### hw/rtl/spdl_dp.sv
// datapath: angle, pending delta, revolution state and rpm estimate
`default_nettype none

module spdl_dp #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spdl_pkg::cmd_t                cmd,
    output spdl_pkg::stat_t                    stat,
    input  wire spdl_pkg::item_t               item,
    input  wire logic [spdl_pkg::PPR_W-1:0]    ppr,
    output spdl_pkg::result_t                  result
);

    localparam int AW    = spdl_pkg::ANGLE_W;
    localparam int PW    = spdl_pkg::POS_W;
    localparam int DW    = spdl_pkg::DELTA_W;
    localparam int CW    = spdl_pkg::ACC_W;
    localparam int DEN_W = spdl_pkg::PPR_W + TIME_BITS;
    localparam int NUM_W = spdl_pkg::NUM_W;
    localparam int GAP_W = CW + 2;

    // architectural state
    logic signed [AW-1:0]  cur_angle_reg, cur_angle_next;
    logic signed [CW-1:0]  pending_reg, pending_next;
    logic [CW-1:0]         rev_ref_pos_reg, rev_ref_pos_next;
    logic [CW-1:0]         rev_size_reg, rev_size_next;
    logic [TIME_BITS-1:0]  rev_duration_reg, rev_duration_next;
    logic [TIME_BITS-1:0]  rev_stamp_reg, rev_stamp_next;

    // per-request working registers
    logic signed [DW-1:0]  delta_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  take_reg;
    logic signed [PW-1:0]  pos_reg;
    logic signed [CW-1:0]  taken_reg;
    logic [CW-1:0]         mag_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [NUM_W-1:0]      num_reg;
    logic                  zero_reg;
    spdl_pkg::result_t     result_reg;

    logic [spdl_pkg::PPR_W-1:0]  ppr_eff;
    logic signed [PW-1:0]        pos_next;
    logic [PW-1:0]               pos_neg;
    logic [AW-1:0]               pos_mag;
    logic [AW-1:0]               rem17;
    logic [AW-1:0]               newpos;
    logic [PW-1:0]               wrap;
    logic signed [CW:0]          sum;
    logic signed [CW-1:0]        sum_sat;
    logic signed [GAP_W-1:0]     ref_gap;
    logic signed [GAP_W-1:0]     ppr_s;
    logic                        far;
    logic [CW-1:0]               size_neg;
    logic [TIME_BITS-1:0]        elapsed;

    logic                        div_done;
    logic [NUM_W-1:0]            div_num;
    logic [DEN_W-1:0]            div_den;
    logic [spdl_pkg::QUOT_W-1:0] div_quot;
    logic [DEN_W-1:0]            div_rem;
    logic                        div_ovf;

    // a zero register value counts as one pulse per revolution
    assign ppr_eff = (ppr == '0) ? spdl_pkg::PPR_W'(1) : ppr;

    assign pos_next = {cur_angle_reg[AW-1], cur_angle_reg}
                    + {{(PW-DW){item.count_delta[DW-1]}}, item.count_delta};
    assign pos_neg  = -pos_reg;
    assign pos_mag  = pos_reg[PW-1] ? pos_neg[AW-1:0] : pos_reg[AW-1:0];

    // truncating remainder takes the sign of the dividend
    assign rem17  = div_rem[AW-1:0];
    assign newpos = pos_reg[PW-1] ? -rem17 : rem17;
    assign wrap   = pos_reg - {newpos[AW-1], newpos};

    assign sum = {pending_reg[CW-1], pending_reg}
               + {{(CW+1-DW){delta_reg[DW-1]}}, delta_reg};
    always_comb
    begin
        priority if (sum[CW] && !sum[CW-1])
        begin
            sum_sat = {1'b1, {(CW-1){1'b0}}};
        end
        else if (!sum[CW] && sum[CW-1])
        begin
            sum_sat = {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[CW-1:0];
        end
    end

    assign ref_gap = {{(GAP_W-AW){cur_angle_reg[AW-1]}}, cur_angle_reg}
                   - {{(GAP_W-CW){rev_ref_pos_reg[CW-1]}}, rev_ref_pos_reg};
    assign ppr_s   = {{(GAP_W-spdl_pkg::PPR_W){1'b0}}, ppr_eff};
    assign far     = (ref_gap > ppr_s) || (ref_gap < -ppr_s);

    assign size_neg = -rev_size_reg;
    assign elapsed  = now_reg - rev_stamp_reg;

    assign div_num = cmd.div_rpm ? num_reg : NUM_W'(pos_mag);
    assign div_den = cmd.div_rpm ? den_reg : DEN_W'(ppr_eff);

    spdl_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem),
        .ovf   (div_ovf)
    );

    assign stat.div_done = div_done;

    always_comb
    begin
        cur_angle_next    = cur_angle_reg;
        pending_next      = pending_reg;
        rev_ref_pos_next  = rev_ref_pos_reg;
        rev_size_next     = rev_size_reg;
        rev_duration_next = rev_duration_reg;
        rev_stamp_next    = rev_stamp_reg;
        if (cmd.apply)
        begin
            cur_angle_next   = newpos;
            rev_ref_pos_next = rev_ref_pos_reg - {{(CW-PW){wrap[PW-1]}}, wrap};
            pending_next     = take_reg ? '0 : sum_sat;
        end
        if (cmd.latch && (delta_reg != '0) && far)
        begin
            rev_size_next     = ref_gap[CW-1:0];
            rev_ref_pos_next  = {{(CW-AW){cur_angle_reg[AW-1]}}, cur_angle_reg};
            rev_duration_next = elapsed;
            rev_stamp_next    = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_angle_reg    <= '0;
            pending_reg      <= '0;
            rev_ref_pos_reg  <= '0;
            rev_size_reg     <= '0;
            rev_duration_reg <= '0;
            rev_stamp_reg    <= '0;
        end
        else
        begin
            cur_angle_reg    <= cur_angle_next;
            pending_reg      <= pending_next;
            rev_ref_pos_reg  <= rev_ref_pos_next;
            rev_size_reg     <= rev_size_next;
            rev_duration_reg <= rev_duration_next;
            rev_stamp_reg    <= rev_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            delta_reg <= item.count_delta;
            now_reg   <= TIME_BITS'(item.time_us);
            take_reg  <= item.consume;
            pos_reg   <= pos_next;
        end
        if (cmd.apply)
        begin
            taken_reg <= take_reg ? sum_sat : '0;
        end
        if (cmd.prep)
        begin
            mag_reg  <= rev_size_reg[CW-1] ? size_neg : rev_size_reg;
            den_reg  <= DEN_W'(ppr_eff) * DEN_W'(rev_duration_reg);
            zero_reg <= (rev_duration_reg == '0)
                     || (elapsed > TIME_BITS'(spdl_pkg::STALE_US));
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(mag_reg) * NUM_W'(spdl_pkg::US_PER_MINUTE);
        end
        if (cmd.load_out)
        begin
            result_reg.angle       <= cur_angle_reg;
            result_reg.taken_delta <= taken_reg;
            if (zero_reg)
            begin
                result_reg.rpm <= '0;
            end
            else if (div_ovf || div_quot[spdl_pkg::QUOT_W-1])
            begin
                result_reg.rpm <= spdl_pkg::RPM_MAX;
            end
            else
            begin
                result_reg.rpm <= div_quot[spdl_pkg::RPM_W-1:0];
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### hw/rtl/spdl_ctrl.sv
// sequencer for one request and the result handshake
`default_nettype none
`include "spindle_encoder_position_rpm_tracker_core_defines.svh"

module spdl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output spdl_pkg::cmd_t        cmd,
    input  wire spdl_pkg::stat_t  stat
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_REM_START = 9'b000000010,
        ST_REM_WAIT  = 9'b000000100,
        ST_LATCH     = 9'b000001000,
        ST_PREP      = 9'b000010000,
        ST_MUL       = 9'b000100000,
        ST_RPM_START = 9'b001000000,
        ST_RPM_WAIT  = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_REM_START;
                end
            end
            ST_REM_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_REM_WAIT;
            end
            ST_REM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                cmd.latch  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RPM_START;
            end
            ST_RPM_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_rpm   = 1'b1;
                state_next    = ST_RPM_WAIT;
            end
            ST_RPM_WAIT:
            begin
                cmd.div_rpm = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    `SPDL_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_reg, "result not shown after load")
    `SPDL_ASSERT_NEVER(a_done_outside_wait, stat.div_done && !(state_reg == ST_REM_WAIT || state_reg == ST_RPM_WAIT), "divider finished outside a wait state")
    `SPDL_ASSERT_NEXT(a_hold_when_blocked, state_reg == ST_DONE && out_valid_reg && !result_ready, state_reg == ST_DONE, "result overwritten while stalled")

endmodule

`default_nettype wire
